[rtl/core/ssm_pkg.sv]
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, register codes and helpers for the substring search matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgLenW  = 6;
  localparam int unsigned LenW     = CfgLenW + 1;
  localparam int unsigned PatWords = 4;
  localparam int unsigned PatBytes = PatWords * CfgDataW / ByteW;
  localparam int unsigned ResPosW  = 16;

  typedef logic [ByteW-1:0]              byte_t;
  typedef logic [LenW-1:0]               len_t;
  typedef logic [PatWords*CfgDataW-1:0]  pat_flat_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic adv;
    logic clr;
  } cell_ctrl_t;

  function automatic byte_t pat_byte(pat_flat_t pat, len_t idx);
    byte_t res;
    res = '0;
    if (idx < len_t'(PatBytes)) begin
      res = pat[idx[4:0]*ByteW +: ByteW];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/substring_search_matcher_top.sv]
// ----------------------------------------------------------------------------
// substring_search_matcher_top
// Streams text bytes through a row of window cells and reports the first
// exact occurrence of the configured pattern, or no match at text end.
// ----------------------------------------------------------------------------
//  channel | valid / ready                 | payload
//  text    | text_valid_i / text_ready_o   | text_byte_i, final_byte_i
//  result  | result_valid_o / result_ready_i | found_o, match_start_o,
//          |                               | position_overflow_o
//  cfg     | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
//  One text item per cycle while text_ready_o is high; the window compare is combinational across all cells.
//  A result is registered at the edge that takes its item.
//  Two output slots: text stalls only with two results waiting and no ready.
//  Reset clears window, byte count and match flag; no clearing pass.
//  Config is always ready and takes one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_search_matcher_top import ssm_pkg::*; #(
  parameter int unsigned MAX_PATTERN   = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [CfgIdxW-1:0]   cfg_index_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  input  wire                 text_valid_i,
  output logic                text_ready_o,
  input  wire [ByteW-1:0]     text_byte_i,
  input  wire                 final_byte_i,
  output logic                result_valid_o,
  input  wire                 result_ready_i,
  output logic                found_o,
  output logic [ResPosW-1:0]  match_start_o,
  output logic                position_overflow_o
);

  localparam int unsigned SeenW  = POSITION_BITS + 1;
  localparam int unsigned CntW   = POSITION_BITS + 2;
  localparam int unsigned StartW = (POSITION_BITS > ResPosW) ? POSITION_BITS : ResPosW;

  // configuration
  logic [CfgLenW-1:0]  len_q;
  logic [CfgDataW-1:0] word_q [PatWords];
  pat_flat_t           pat_flat;
  len_t                eff_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= CfgLenW'(1);
      for (int i = 0; i < PatWords; i++) begin
        word_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_LENGTH: len_q     <= cfg_data_i[CfgLenW-1:0];
        REG_PATTERN_WORD_0: word_q[0] <= cfg_data_i;
        REG_PATTERN_WORD_1: word_q[1] <= cfg_data_i;
        REG_PATTERN_WORD_2: word_q[2] <= cfg_data_i;
        REG_PATTERN_WORD_3: word_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pat_flat = {word_q[3], word_q[2], word_q[1], word_q[0]};

  always_comb begin
    eff_len = {1'b0, len_q};
    if (len_q == '0) begin
      eff_len = len_t'(1);
    end else if (eff_len > len_t'(MAX_PATTERN)) begin
      eff_len = len_t'(MAX_PATTERN);
    end
  end

  // text state
  logic [SeenW-1:0] seen_q, seen_d;
  logic             match_q, match_d;
  logic             in_acc, overflow, enough, hit;
  logic [CntW-1:0]  idx_p1;
  logic [POSITION_BITS-1:0] start;
  logic [StartW-1:0] start_ext;
  cell_ctrl_t       ctrl;

  byte_t chain  [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] cell_hit;

  assign in_acc   = text_valid_i && text_ready_o;
  assign overflow = seen_q[POSITION_BITS];
  assign idx_p1   = CntW'(seen_q) + CntW'(1);
  assign enough   = idx_p1 >= CntW'(eff_len);
  assign hit      = enough && (&cell_hit);
  assign start    = overflow ? {POSITION_BITS{1'b1}}
                             : POSITION_BITS'(idx_p1 - CntW'(eff_len));
  assign start_ext = StartW'(start);

  assign chain[0] = text_byte_i;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    len_t  pidx;
    byte_t pat;
    logic  en;
    assign en   = len_t'(k) < eff_len;
    assign pidx = eff_len - len_t'(k) - len_t'(1);
    assign pat  = pat_byte(pat_flat, pidx);

    ssm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .shift_i (chain[k]),
      .pat_i   (pat),
      .en_i    (en),
      .byte_o  (chain[k+1]),
      .hit_o   (cell_hit[k])
    );
  end

  // result slots: head drives the outputs, skid holds the next result
  logic                res_load, res_pop;
  logic [1:0]          res_cnt_q, res_cnt_d;
  logic                found_q, found_d;
  logic [ResPosW-1:0]  start_q, start_d;
  logic                ovf_q, ovf_d;
  logic                sk_found_q;
  logic [ResPosW-1:0]  sk_start_q;
  logic                sk_ovf_q;

  always_comb begin
    ctrl     = '0;
    seen_d   = seen_q;
    match_d  = match_q;
    res_load = 1'b0;
    found_d  = 1'b0;
    start_d  = '0;
    ovf_d    = overflow;
    if (in_acc) begin
      if (match_q) begin
        if (final_byte_i) begin
          ctrl.clr = 1'b1;
          seen_d   = '0;
          match_d  = 1'b0;
        end
      end else begin
        ctrl.adv = 1'b1;
        if (!overflow) begin
          seen_d = seen_q + SeenW'(1);
        end
        if (hit) begin
          res_load = 1'b1;
          found_d  = 1'b1;
          start_d  = start_ext[ResPosW-1:0];
          match_d  = 1'b1;
        end else if (final_byte_i) begin
          res_load = 1'b1;
        end
        if (final_byte_i) begin
          ctrl.clr = 1'b1;
          seen_d   = '0;
          match_d  = 1'b0;
        end
      end
    end
  end

  assign res_pop = (res_cnt_q != 2'd0) && result_ready_i;

  always_comb begin
    res_cnt_d = res_cnt_q;
    case ({res_load, res_pop})
      2'b10:   res_cnt_d = res_cnt_q + 2'd1;
      2'b01:   res_cnt_d = res_cnt_q - 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      match_q   <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      seen_q    <= seen_d;
      match_q   <= match_d;
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_pop && (res_cnt_q == 2'd2)) begin
      found_q <= sk_found_q;
      start_q <= sk_start_q;
      ovf_q   <= sk_ovf_q;
    end else if (res_load && ((res_cnt_q == 2'd0) || res_pop)) begin
      found_q <= found_d;
      start_q <= start_d;
      ovf_q   <= ovf_d;
    end
    if (res_load && ((res_cnt_q == 2'd2) || ((res_cnt_q == 2'd1) && !res_pop))) begin
      sk_found_q <= found_d;
      sk_start_q <= start_d;
      sk_ovf_q   <= ovf_d;
    end
  end

  assign text_ready_o        = (res_cnt_q != 2'd2) || result_ready_i;
  assign result_valid_o      = (res_cnt_q != 2'd0);
  assign found_o             = found_q;
  assign match_start_o       = start_q;
  assign position_overflow_o = ovf_q;

  // checks
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && final_byte_i |=> seen_q == '0 && !match_q)
    else $error("text state not cleared after final item");

  a_hit_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !match_q && hit |=> result_valid_o)
    else $error("window hit gave no result");

  a_silent_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && match_q |-> !res_load)
    else $error("result after match already reported");

  a_match_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && match_q && !final_byte_i |=> match_q)
    else $error("match flag dropped inside a text");

endmodule

`default_nettype wire

[rtl/core/ssm_cell.sv]
// ----------------------------------------------------------------------------
// ssm_cell
// One window cell: holds one text byte, passes it on, compares its next value.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_cell import ssm_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire byte_t      shift_i,
  input  wire byte_t      pat_i,
  input  wire             en_i,
  output byte_t           byte_o,
  output logic            hit_o
);

  byte_t byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clr) begin
      byte_d = '0;
    end else if (ctrl_i.adv) begin
      byte_d = shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = !en_i || (shift_i == pat_i);

endmodule

`default_nettype wire

[tb/tb_substring_search_matcher_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_substring_search_matcher_top
// Streams texts into the matcher under random handshake pacing, predicts the
// first match or the no-match result of each text, and checks every result
// field by field. Covers register settings and long output stalls.
// ----------------------------------------------------------------------------
module tb_substring_search_matcher_top;
  import ssm_pkg::*;

  localparam int unsigned ClkHalf    = 5;
  localparam int unsigned WinDepth   = 32;
  localparam int unsigned PosLimit   = 1 << 16;
  localparam longint      CycleLimit = 2_000_000;

  typedef struct packed {
    logic               found;
    logic [ResPosW-1:0] start;
    logic               ovf;
  } match_res_t;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  cfg_reg_e            cfg_index_i = REG_PATTERN_LENGTH;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                text_valid_i = 1'b0;
  logic                text_ready_o;
  byte_t               text_byte_i = '0;
  logic                final_byte_i = 1'b0;
  logic                result_valid_o;
  logic                result_ready_i = 1'b0;
  logic                found_o;
  logic [ResPosW-1:0]  match_start_o;
  logic                position_overflow_o;

  // matcher model state
  byte_t               win_q [WinDepth];
  logic [16:0]         seen_q;
  logic                reported_q;
  logic [CfgLenW-1:0]  len_reg_q;
  logic [CfgDataW-1:0] pat_word_q [PatWords];
  match_res_t          match_q [$];

  byte_t               pat_bytes_next [PatBytes];
  byte_t               alpha [4];
  int unsigned         alpha_n;
  byte_t               text_buf [$];
  logic                gaps_on;
  int unsigned         burst_left;
  int unsigned         hold_off_cycles;
  longint              cycle_cnt;
  int unsigned         items_sent, texts_sent, err_cnt;
  int unsigned         found_seen, miss_seen, ovf_seen;

  substring_search_matcher_top #(
    .MAX_PATTERN  (WinDepth),
    .POSITION_BITS(16)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .text_valid_i       (text_valid_i),
    .text_ready_o       (text_ready_o),
    .text_byte_i        (text_byte_i),
    .final_byte_i       (final_byte_i),
    .result_valid_o     (result_valid_o),
    .result_ready_i     (result_ready_i),
    .found_o            (found_o),
    .match_start_o      (match_start_o),
    .position_overflow_o(position_overflow_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  function automatic int unsigned active_len();
    int unsigned l;
    l = len_reg_q;
    if (l == 0) l = 1;
    if (l > WinDepth) l = WinDepth;
    return l;
  endfunction

  function automatic byte_t pattern_at(int unsigned i);
    return pat_word_q[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic void clear_window();
    int k;
    for (k = 0; k < WinDepth; k++) win_q[k] = '0;
    seen_q = '0;
    reported_q = 1'b0;
  endfunction

  function automatic void predict_byte(byte_t b, logic fin);
    logic [16:0] idx;
    logic        ovf;
    logic        hit;
    int unsigned l;
    int          k;
    match_res_t  r;
    idx = seen_q;
    ovf = (idx >= PosLimit);
    l = active_len();
    if (reported_q) begin
      if (fin) clear_window();
      return;
    end
    for (k = WinDepth - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = b;
    if (seen_q < PosLimit) seen_q = seen_q + 1'b1;
    hit = (idx + 1 >= l);
    for (k = 0; k < l; k++) begin
      if (win_q[k] != pattern_at(l - 1 - k)) hit = 1'b0;
    end
    if (hit) begin
      r.found = 1'b1;
      r.start = ovf ? '1 : ResPosW'(idx + 1 - l);
      r.ovf   = ovf;
      match_q.push_back(r);
      if (fin) clear_window();
      else reported_q = 1'b1;
    end else if (fin) begin
      r = '0;
      r.ovf = ovf;
      match_q.push_back(r);
      clear_window();
    end
  endfunction

  function automatic byte_t pick_byte();
    if (alpha_n == 0) return byte_t'($urandom_range(1, 255));
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_PATTERN_LENGTH) len_reg_q = data[CfgLenW-1:0];
    else pat_word_q[idx - REG_PATTERN_WORD_0] = data;
  endtask

  task automatic settle_idle();
    text_valid_i <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_pattern(logic [CfgLenW-1:0] len_sel);
    logic [CfgDataW-1:0] data;
    int                  w, i;
    settle_idle();
    write_reg(REG_PATTERN_LENGTH, {$urandom(), 26'($urandom()), len_sel});
    for (w = 0; w < PatWords; w++) begin
      for (i = 0; i < 8; i++) data[8*i +: 8] = pat_bytes_next[8*w + i];
      write_reg(cfg_reg_e'(REG_PATTERN_WORD_0 + w), data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(byte_t b, logic fin);
    text_valid_i <= 1'b1;
    text_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!text_ready_o);
    predict_byte(b, fin);
    items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        text_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++) send_item(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
  endtask

  task automatic build_random_text();
    int unsigned l, kind;
    int          i;
    text_buf.delete();
    l = active_len();
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      repeat ($urandom_range(0, 12)) text_buf.push_back(pick_byte());
      for (i = 0; i < l; i++) text_buf.push_back(pattern_at(i));
      repeat ($urandom_range(0, 5)) text_buf.push_back(pick_byte());
    end else if (kind < 8) begin
      repeat ($urandom_range(0, 6)) text_buf.push_back(pick_byte());
      for (i = 0; i + 1 < l; i++) text_buf.push_back(pattern_at(i));
      if (text_buf.size() == 0) text_buf.push_back(pick_byte());
    end else begin
      repeat ($urandom_range(1, 24)) text_buf.push_back(byte_t'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_reset_defaults();
    gaps_on = 1'b1;
    send_item(8'h00, 1'b1);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b1);
  endtask

  task automatic test_directed_pattern();
    int i;
    for (i = 0; i < PatBytes; i++) pat_bytes_next[i] = byte_t'($urandom_range(0, 255));
    pat_bytes_next[0] = 8'h61;
    pat_bytes_next[1] = 8'h62;
    pat_bytes_next[2] = 8'h63;
    load_pattern(6'd3);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b1);
    send_item(8'h78, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b0);
    send_item(8'h79, 1'b0);
    send_item(8'h7A, 1'b1);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b1);
    send_item(8'h63, 1'b1);
  endtask

  task automatic test_length_clamp();
    pat_bytes_next[0] = 8'hFF;
    load_pattern(6'd0);
    send_item(8'h01, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
  endtask

  task automatic test_random_phases();
    logic [CfgLenW-1:0] len_sel;
    int                 ph, i;
    int unsigned        start_cnt;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: len_sel = 6'd1;
        1: len_sel = 6'd32;
        2: len_sel = 6'd63;
        3: len_sel = 6'd0;
        4: len_sel = 6'd2;
        default: len_sel = CfgLenW'($urandom_range(3, 31));
      endcase
      alpha_n = (ph % 2 == 1) ? $urandom_range(2, 3) : 0;
      for (i = 0; i < 4; i++) alpha[i] = byte_t'($urandom_range(1, 255));
      for (i = 0; i < PatBytes; i++) pat_bytes_next[i] = pick_byte();
      load_pattern(len_sel);
      gaps_on = (ph != 4);
      start_cnt = items_sent;
      while (items_sent - start_cnt < 70) begin
        build_random_text();
        send_text();
      end
    end
  endtask

  task automatic test_backpressure();
    settle_idle();
    gaps_on = 1'b0;
    hold_off_cycles = 300;
    repeat (48) begin
      send_item(byte_t'($urandom_range(1, 255)), 1'b1);
      texts_sent++;
    end
  endtask

  task automatic test_drain_pause();
    gaps_on = 1'b1;
    repeat (6) begin
      settle_idle();
      build_random_text();
      send_text();
    end
  endtask

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("Watchdog expired after %0d cycles with %0d results pending",
             cycle_cnt, match_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left, beat;
    mode = SINK_OPEN;
    mode_left = 0;
    beat = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        result_ready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 160);
        end else begin
          mode_left--;
        end
        beat++;
        case (mode)
          SINK_OPEN:   result_ready_i <= 1'b1;
          SINK_RANDOM: result_ready_i <= ($urandom_range(0, 99) < 55);
          default:     result_ready_i <= (beat % 7) > 2;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    match_res_t want, got;
    if (rst_ni && result_valid_o && result_ready_i) begin
      got = {found_o, match_start_o, position_overflow_o};
      if (got.found === 1'b1) found_seen++;
      else miss_seen++;
      if (got.ovf === 1'b1) ovf_seen++;
      if (match_q.size() == 0) begin
        err_cnt++;
        $display("%0t ns: result with none pending, expected nothing actual %0h",
                 $time, got);
      end else begin
        want = match_q.pop_front();
        check_field("found", want.found, got.found);
        check_field("match_start", want.start, got.start);
        check_field("position_overflow", want.ovf, got.ovf);
      end
    end
  end

  initial begin : run
    cycle_cnt = 0;
    items_sent = 0;
    texts_sent = 0;
    err_cnt = 0;
    found_seen = 0;
    miss_seen = 0;
    ovf_seen = 0;
    hold_off_cycles = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    alpha_n = 0;
    len_reg_q = 1;
    for (int w = 0; w < PatWords; w++) pat_word_q[w] = '0;
    clear_window();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_pattern();
    test_length_clamp();
    test_random_phases();
    test_backpressure();
    test_drain_pause();

    settle_idle();
    repeat (10) @(posedge clk_i);
    $display("Streamed %0d text bytes in %0d texts over pattern lengths 1 to 32,",
             items_sent, texts_sent);
    $display("clamped lengths and a long output stall; %0d found,", found_seen);
    $display("%0d without a match, %0d past the position range.", miss_seen, ovf_seen);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
